FILE: rtl/rv64se_pkg.sv
// shared definitions for the rv64 subset execute block
// opcodes, field widths, memory geometry and the execute result record
// no dependencies
package rv64se_pkg;

  localparam int XLEN       = 64;
  localparam int PC_W       = 32;
  localparam int INST_W     = 32;
  localparam int REG_AW     = 5;
  localparam int REG_COUNT  = 1 << REG_AW;
  localparam int SP_W       = 15;

  // data memory depth in doublewords, a power of two
  localparam int DATA_WORDS = 2048;
  localparam int DMEM_AW    = $clog2(DATA_WORDS);

  localparam logic [SP_W-1:0]   STACK_TOP_RESET = SP_W'(16384);
  localparam logic [REG_AW-1:0] SP_REG          = REG_AW'(2);
  localparam logic [REG_AW-1:0] ZERO_REG        = REG_AW'(0);

  localparam logic [6:0] OP_ADD_SUB = 7'b0110011;
  localparam logic [6:0] OP_ADDI    = 7'b0010011;
  localparam logic [6:0] OP_LD      = 7'b0000011;
  localparam logic [6:0] OP_SD      = 7'b0100011;
  localparam logic [6:0] OP_BRANCH  = 7'b1100011;
  localparam logic [6:0] OP_JAL     = 7'b1101111;

  localparam logic [2:0] F3_BEQ = 3'd0;
  localparam logic [2:0] F3_BNE = 3'd1;
  localparam logic [2:0] F3_BLT = 3'd4;
  localparam logic [2:0] F3_BGE = 3'd5;

  // register file write port
  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] addr;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

  // outcome of one executed instruction
  typedef struct packed {
    logic [PC_W-1:0]    next_pc;
    logic               wr;
    logic [REG_AW-1:0]  rd;
    logic [XLEN-1:0]    val;
    logic               memw;
    logic               taken;
    logic               illegal;
    logic               is_load;
    logic [DMEM_AW-1:0] mem_addr;
    logic [XLEN-1:0]    store_data;
  } exec_t;

endpackage

FILE: rtl/rv64se_regfile.sv
// 32 x 64 register file, one write port and two registered read ports
// per-entry valid bits give the reset contents, x2 falls back to the stack top
// depends on rv64se_pkg
module rv64se_regfile (
  input  logic                          clk,
  input  logic                          rst,
  input  rv64se_pkg::rf_wr_t            wr,
  input  logic                          re,
  input  logic [rv64se_pkg::REG_AW-1:0] raddr1,
  input  logic [rv64se_pkg::REG_AW-1:0] raddr2,
  input  logic                          sp_reload,
  input  logic [rv64se_pkg::SP_W-1:0]   stack_top,
  output logic [rv64se_pkg::XLEN-1:0]   rdata1,
  output logic [rv64se_pkg::XLEN-1:0]   rdata2
);
  import rv64se_pkg::*;

  logic [XLEN-1:0]      regs [REG_COUNT];
  logic [REG_COUNT-1:0] valid;
  logic [XLEN-1:0]      sp_default;

  assign sp_default = {{(XLEN-SP_W){1'b0}}, stack_top};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (wr.we) begin
        valid[wr.addr] <= 1'b1;
      end
      if (sp_reload) begin
        valid[SP_REG] <= 1'b0;
      end
    end
  end

  // write data of the same edge is forwarded to the reads
  always_ff @(posedge clk) begin
    if (wr.we) begin
      regs[wr.addr] <= wr.data;
    end
    if (re) begin
      if (wr.we && wr.addr == raddr1) begin
        rdata1 <= wr.data;
      end else if (valid[raddr1]) begin
        rdata1 <= regs[raddr1];
      end else if (raddr1 == SP_REG) begin
        rdata1 <= sp_default;
      end else begin
        rdata1 <= '0;
      end
      if (wr.we && wr.addr == raddr2) begin
        rdata2 <= wr.data;
      end else if (valid[raddr2]) begin
        rdata2 <= regs[raddr2];
      end else if (raddr2 == SP_REG) begin
        rdata2 <= sp_default;
      end else begin
        rdata2 <= '0;
      end
    end
  end

endmodule

FILE: rtl/rv64se_dmem.sv
// doubleword data memory, one write and one registered read per cycle
// contents are undefined until written
// depends on rv64se_pkg
module rv64se_dmem (
  input  logic                           clk,
  input  logic                           we,
  input  logic                           re,
  input  logic [rv64se_pkg::DMEM_AW-1:0] addr,
  input  logic [rv64se_pkg::XLEN-1:0]    wdata,
  output logic [rv64se_pkg::XLEN-1:0]    rdata
);
  import rv64se_pkg::*;

  logic [XLEN-1:0] mem [DATA_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/rv64se_exec.sv
// decode and execute of one instruction against pc and two operands
// purely combinational, produces the execute result record
// depends on rv64se_pkg
module rv64se_exec (
  input  logic [rv64se_pkg::INST_W-1:0] ins,
  input  logic [rv64se_pkg::PC_W-1:0]   pc,
  input  logic [rv64se_pkg::XLEN-1:0]   a,
  input  logic [rv64se_pkg::XLEN-1:0]   b,
  output rv64se_pkg::exec_t             ex
);
  import rv64se_pkg::*;

  logic [6:0]        opcode;
  logic [2:0]        funct3;
  logic [6:0]        funct7;
  logic [REG_AW-1:0] rd;
  logic [XLEN-1:0]   imm_i;
  logic [XLEN-1:0]   imm_s;
  logic [XLEN-1:0]   imm_b;
  logic [XLEN-1:0]   imm_j;
  logic [XLEN-1:0]   addr_sum;
  logic [PC_W-1:0]   pc_plus4;
  logic              wr;
  logic [XLEN-1:0]   val;
  logic              taken;
  logic [PC_W-1:0]   next_pc;
  logic              memw;
  logic              illegal;
  logic              is_load;

  assign opcode = ins[6:0];
  assign rd     = ins[11:7];
  assign funct3 = ins[14:12];
  assign funct7 = ins[31:25];

  assign imm_i = {{52{ins[31]}}, ins[31:20]};
  assign imm_s = {{52{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

  assign pc_plus4 = pc + PC_W'(4);
  // byte address for loads and stores, word index drops the low three bits
  assign addr_sum = a + ((opcode == OP_SD) ? imm_s : imm_i);

  always_comb begin
    wr      = 1'b0;
    val     = '0;
    taken   = 1'b0;
    next_pc = pc_plus4;
    memw    = 1'b0;
    illegal = 1'b0;
    is_load = 1'b0;
    case (opcode)
      OP_ADD_SUB: begin
        val = (funct7 == 7'd0) ? a + b : a - b;
        wr  = 1'b1;
      end
      OP_ADDI: begin
        val = addr_sum;
        wr  = 1'b1;
      end
      OP_LD: begin
        wr      = 1'b1;
        is_load = 1'b1;
      end
      OP_SD: begin
        memw = 1'b1;
      end
      OP_BRANCH: begin
        case (funct3)
          F3_BEQ:  taken = (a == b);
          F3_BNE:  taken = (a != b);
          F3_BLT:  taken = ($signed(a) < $signed(b));
          F3_BGE:  taken = ($signed(a) >= $signed(b));
          default: taken = 1'b0;
        endcase
        if (taken) begin
          next_pc = pc + imm_b[PC_W-1:0];
        end
      end
      OP_JAL: begin
        val     = {{(XLEN-PC_W){1'b0}}, pc_plus4};
        wr      = 1'b1;
        taken   = 1'b1;
        next_pc = pc + imm_j[PC_W-1:0];
      end
      default: begin
        illegal = 1'b1;
      end
    endcase
  end

  // writes to x0 are dropped and reported as no write
  assign ex.next_pc    = next_pc;
  assign ex.wr         = wr && (rd != ZERO_REG);
  assign ex.rd         = ex.wr ? rd : ZERO_REG;
  assign ex.val        = ex.wr ? val : '0;
  assign ex.memw       = memw;
  assign ex.taken      = taken;
  assign ex.illegal    = illegal;
  assign ex.is_load    = is_load;
  assign ex.mem_addr   = addr_sum[3 +: DMEM_AW];
  assign ex.store_data = b;

endmodule

FILE: rtl/rv64_subset_execute.sv
// rv64 subset execute unit: add/sub, addi, ld, sd, beq, bne, blt, bge, jal
// result path: execute stage registers, then output registers; ld adds the memory stage
// throughput: one request per cycle while the output is not stalled; a request after ld
//   waits for the memory stage, set by the registered read port of the data memory
// reset (synchronous): pc 0, stack top 16384, registers zero with x2 at stack top,
//   no clearing pass; data memory is left undefined
module rv64_subset_execute (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rv64se_pkg::SP_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rv64se_pkg::INST_W-1:0] instruction,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rv64se_pkg::PC_W-1:0]   next_pc,
  output logic                          reg_written,
  output logic [rv64se_pkg::REG_AW-1:0] dest_index,
  output logic [rv64se_pkg::XLEN-1:0]   dest_value,
  output logic                          mem_written,
  output logic                          branch_taken,
  output logic                          illegal
);
  import rv64se_pkg::*;

  logic [SP_W-1:0]   stack_top;
  logic [PC_W-1:0]   pc;
  logic              x_valid;
  logic [INST_W-1:0] x_inst;
  logic [XLEN-1:0]   rs1_val;
  logic [XLEN-1:0]   rs2_val;
  logic              m_valid;
  logic [PC_W-1:0]   m_next_pc;
  logic              m_wr;
  logic [REG_AW-1:0] m_rd;
  logic [XLEN-1:0]   load_data;

  exec_t  ex;
  rf_wr_t rf_wr;
  logic   cfg_fire;
  logic   in_fire;
  logic   out_free;
  logic   x_fire;
  logic   m_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign out_free = !out_valid || out_ready;
  assign m_fire   = m_valid && out_free;
  // execute waits for a pending load; a load itself goes on to the memory stage
  assign x_fire   = x_valid && !m_valid && (ex.is_load || out_free);
  // operands are read at accept, so every older write must land on that edge
  assign in_ready = (!x_valid || (x_fire && !ex.is_load)) && (!m_valid || m_fire);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    rf_wr.we   = 1'b0;
    rf_wr.addr = ex.rd;
    rf_wr.data = ex.val;
    if (m_fire) begin
      rf_wr.we   = m_wr;
      rf_wr.addr = m_rd;
      rf_wr.data = load_data;
    end else if (x_fire && !ex.is_load) begin
      rf_wr.we = ex.wr;
    end
  end

  rv64se_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .wr        (rf_wr),
    .re        (in_fire),
    .raddr1    (instruction[19:15]),
    .raddr2    (instruction[24:20]),
    .sp_reload (cfg_fire),
    .stack_top (stack_top),
    .rdata1    (rs1_val),
    .rdata2    (rs2_val)
  );

  rv64se_exec u_exec (
    .ins (x_inst),
    .pc  (pc),
    .a   (rs1_val),
    .b   (rs2_val),
    .ex  (ex)
  );

  rv64se_dmem u_dmem (
    .clk   (clk),
    .we    (x_fire && ex.memw),
    .re    (x_fire && ex.is_load),
    .addr  (ex.mem_addr),
    .wdata (ex.store_data),
    .rdata (load_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_top <= STACK_TOP_RESET;
      pc        <= '0;
      x_valid   <= 1'b0;
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_fire) begin
        stack_top <= cfg_data;
      end
      if (x_fire) begin
        pc <= ex.next_pc;
      end
      if (in_fire) begin
        x_valid <= 1'b1;
      end else if (x_fire) begin
        x_valid <= 1'b0;
      end
      if (x_fire && ex.is_load) begin
        m_valid <= 1'b1;
      end else if (m_fire) begin
        m_valid <= 1'b0;
      end
      if (m_fire || (x_fire && !ex.is_load)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_inst <= instruction;
    end
    if (x_fire && ex.is_load) begin
      m_next_pc <= ex.next_pc;
      m_wr      <= ex.wr;
      m_rd      <= ex.rd;
    end
    if (m_fire) begin
      next_pc      <= m_next_pc;
      reg_written  <= m_wr;
      dest_index   <= m_rd;
      dest_value   <= m_wr ? load_data : '0;
      mem_written  <= 1'b0;
      branch_taken <= 1'b0;
      illegal      <= 1'b0;
    end else if (x_fire && !ex.is_load) begin
      next_pc      <= ex.next_pc;
      reg_written  <= ex.wr;
      dest_index   <= ex.rd;
      dest_value   <= ex.val;
      mem_written  <= ex.memw;
      branch_taken <= ex.taken;
      illegal      <= ex.illegal;
    end
  end

`ifndef SYNTHESIS
  a_load_enters_mem: assert property (@(posedge clk) disable iff (rst)
    x_fire && ex.is_load |=> m_valid)
    else $error("load did not reach the memory stage");

  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    rf_wr.we |-> rf_wr.addr != ZERO_REG)
    else $error("register file write to x0");

  a_dest_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && reg_written |-> dest_index != ZERO_REG)
    else $error("reported write to x0");

  a_illegal_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && illegal |-> !reg_written && !mem_written && !branch_taken)
    else $error("illegal instruction changed state");
`endif

endmodule

FILE: test/rv64se_tb_pkg.sv
`timescale 1ns / 1ps
// scoreboard for the rv64 subset execute testbench: instruction predictor and result checks
// depends on rv64se_pkg for widths, opcodes and memory geometry
package rv64se_tb_pkg;
  import rv64se_pkg::*;

  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic              reg_written;
    logic [REG_AW-1:0] dest_index;
    logic [XLEN-1:0]   dest_value;
    logic              mem_written;
    logic              branch_taken;
    logic              illegal;
  } exec_result_t;

  class execute_scoreboard;
    logic [PC_W-1:0] pc;
    logic [XLEN-1:0] regs [REG_COUNT];
    logic [XLEN-1:0] dmem [DATA_WORDS];
    bit              stored [DATA_WORDS];
    int unsigned     stored_words [$];
    exec_result_t    awaited [$];
    int unsigned     failures;

    function new();
      pc = '0;
      foreach (regs[i]) regs[i] = '0;
      regs[SP_REG] = XLEN'(STACK_TOP_RESET);
      foreach (stored[i]) stored[i] = 1'b0;
      failures = 0;
    endfunction

    function logic [DMEM_AW-1:0] word_of(logic [XLEN-1:0] addr);
      return addr[DMEM_AW+2:3];
    endfunction

    // a stack top write also reloads x2
    function void set_stack_top(logic [SP_W-1:0] value);
      regs[SP_REG] = XLEN'(value);
    endfunction

    function bit load_hits_stored(logic [INST_W-1:0] ins);
      return stored[word_of(regs[ins[19:15]] + {{52{ins[31]}}, ins[31:20]})];
    endfunction

    function void execute_request(logic [INST_W-1:0] ins);
      logic [XLEN-1:0]    a, b, imm, val;
      logic [PC_W-1:0]    target;
      logic [REG_AW-1:0]  rd;
      logic [DMEM_AW-1:0] slot;
      logic               wr, memw, taken, bad;
      exec_result_t       outcome;
      a = regs[ins[19:15]];
      b = regs[ins[24:20]];
      rd = ins[11:7];
      target = pc + PC_W'(4);
      val = '0;
      wr = 1'b0;
      memw = 1'b0;
      taken = 1'b0;
      bad = 1'b0;
      case (ins[6:0])
        OP_ADD_SUB: begin
          val = (ins[31:25] == 7'd0) ? a + b : a - b;
          wr = 1'b1;
        end
        OP_ADDI: begin
          val = a + {{52{ins[31]}}, ins[31:20]};
          wr = 1'b1;
        end
        OP_LD: begin
          val = dmem[word_of(a + {{52{ins[31]}}, ins[31:20]})];
          wr = 1'b1;
        end
        OP_SD: begin
          imm = {{52{ins[31]}}, ins[31:25], ins[11:7]};
          slot = word_of(a + imm);
          dmem[slot] = b;
          if (!stored[slot]) stored_words.push_back(slot);
          stored[slot] = 1'b1;
          memw = 1'b1;
        end
        OP_BRANCH: begin
          imm = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
          case (ins[14:12])
            F3_BEQ: taken = (a == b);
            F3_BNE: taken = (a != b);
            F3_BLT: taken = ($signed(a) < $signed(b));
            F3_BGE: taken = ($signed(a) >= $signed(b));
            default: taken = 1'b0;
          endcase
          if (taken) target = pc + imm[PC_W-1:0];
        end
        OP_JAL: begin
          imm = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
          // return address wraps within 32 bits
          val = {{(XLEN-PC_W){1'b0}}, pc + PC_W'(4)};
          wr = 1'b1;
          taken = 1'b1;
          target = pc + imm[PC_W-1:0];
        end
        default: bad = 1'b1;
      endcase
      if (wr && rd != ZERO_REG) begin
        regs[rd] = val;
      end else begin
        wr = 1'b0;
        rd = ZERO_REG;
        val = '0;
      end
      pc = target;
      outcome.next_pc = target;
      outcome.reg_written = wr;
      outcome.dest_index = rd;
      outcome.dest_value = val;
      outcome.mem_written = memw;
      outcome.branch_taken = taken;
      outcome.illegal = bad;
      awaited.push_back(outcome);
    endfunction

    function void check_result(exec_result_t got);
      exec_result_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: pc=%h wr=%b rd=%0d val=%h mw=%b tk=%b ill=%b",
                   got.next_pc, got.reg_written, got.dest_index, got.dest_value,
                   got.mem_written, got.branch_taken, got.illegal);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected pc=%h wr=%b rd=%0d val=%h mw=%b tk=%b ill=%b",
                   want.next_pc, want.reg_written, want.dest_index, want.dest_value,
                   want.mem_written, want.branch_taken, want.illegal);
          $display("          actual   pc=%h wr=%b rd=%0d val=%h mw=%b tk=%b ill=%b",
                   got.next_pc, got.reg_written, got.dest_index, got.dest_value,
                   got.mem_written, got.branch_taken, got.illegal);
        end
      end
    endfunction
  endclass

endpackage

FILE: test/testbench.sv
`timescale 1ns / 1ps
// top-level testbench for rv64_subset_execute: directed and random instruction streams
// depends on rv64se_pkg and the scoreboard in rv64se_tb_pkg
module testbench;
  import rv64se_pkg::*;
  import rv64se_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SPAN_W      = DMEM_AW + 3;
  localparam logic [2:0] F3_UNUSED_LO = 3'd2;
  localparam logic [2:0] F3_UNUSED_HI = 3'd7;
  localparam logic [2:0] BRANCH_F3 [4] = '{F3_BEQ, F3_BNE, F3_BLT, F3_BGE};

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_e;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SP_W-1:0]   cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [INST_W-1:0] instruction = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PC_W-1:0]   next_pc;
  logic              reg_written;
  logic [REG_AW-1:0] dest_index;
  logic [XLEN-1:0]   dest_value;
  logic              mem_written;
  logic              branch_taken;
  logic              illegal;

  execute_scoreboard sb = new();
  exec_result_t      seen;
  bit                pressure_phase = 1'b0;
  int unsigned       burst_left = 0;
  int unsigned       cycle_count = 0;

  rv64_subset_execute u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .instruction  (instruction),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .next_pc      (next_pc),
    .reg_written  (reg_written),
    .dest_index   (dest_index),
    .dest_value   (dest_value),
    .mem_written  (mem_written),
    .branch_taken (branch_taken),
    .illegal      (illegal)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen.next_pc = next_pc;
      seen.reg_written = reg_written;
      seen.dest_index = dest_index;
      seen.dest_value = dest_value;
      seen.mem_written = mem_written;
      seen.branch_taken = branch_taken;
      seen.illegal = illegal;
      sb.check_result(seen);
    end
  end

  // receiver: stall mode is redrawn at random, one long hold-off
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  bit          held_once = 1'b0;
  rx_mode_e    stall_mode = RX_OPEN;
  logic [15:0] ready_mask = 16'hffff;

  always @(posedge clk) begin
    if (pressure_phase && !held_once) begin
      held_once = 1'b1;
      hold_left = 400;
    end
    if (mode_left == 0) begin
      stall_mode = rx_mode_e'($urandom_range(3));
      mode_left = $urandom_range(20, 120);
      ready_mask = 16'($urandom);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(1));
        RX_SPARSE: out_ready <= ($urandom_range(3) == 0);
        default: begin
          out_ready <= ready_mask[0];
          ready_mask = {ready_mask[0], ready_mask[15:1]};
        end
      endcase
    end
  end

  function automatic logic [INST_W-1:0] enc_i(input logic [6:0] op, input logic [11:0] imm,
                                              input logic [4:0] rs1, input logic [4:0] rd);
    return {imm, rs1, 3'b000, rd, op};
  endfunction

  function automatic logic [INST_W-1:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                              input logic [4:0] rs1, input logic [4:0] rd);
    return {f7, rs2, rs1, 3'b000, rd, OP_ADD_SUB};
  endfunction

  function automatic logic [INST_W-1:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                              input logic [4:0] rs1);
    return {imm[11:5], rs2, rs1, 3'b011, imm[4:0], OP_SD};
  endfunction

  function automatic logic [INST_W-1:0] enc_b(input logic [2:0] f3, input logic [12:0] imm,
                                              input logic [4:0] rs1, input logic [4:0] rs2);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [INST_W-1:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  // mostly the low registers so results feed later requests
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(2) != 0) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
  endfunction

  // ld aimed at a word that was already stored; falls back to addi if none is in reach
  function automatic logic [INST_W-1:0] load_from_stored(input logic [4:0] rd);
    logic [SPAN_W-1:0] target, span;
    logic [4:0]        base;
    int unsigned       first;
    if (sb.stored_words.size() == 0) return enc_i(OP_ADDI, 12'($urandom), pick_reg(), rd);
    target = {DMEM_AW'(sb.stored_words[$urandom_range(sb.stored_words.size() - 1)]),
              3'($urandom)};
    first = $urandom_range(31);
    for (int k = 0; k < REG_COUNT; k++) begin
      base = 5'(first + k);
      span = target - sb.regs[base][SPAN_W-1:0];
      if (span < SPAN_W'(2048) || span >= SPAN_W'((1 << SPAN_W) - 2048))
        return enc_i(OP_LD, span[11:0], base, rd);
    end
    return enc_i(OP_ADDI, 12'($urandom), pick_reg(), rd);
  endfunction

  function automatic logic [INST_W-1:0] random_instruction();
    logic [INST_W-1:0] ins;
    int unsigned       pick;
    ins = $urandom;
    pick = $urandom_range(99);
    ins[11:7] = pick_reg();
    ins[19:15] = pick_reg();
    ins[24:20] = pick_reg();
    if (pick < 18) begin
      ins[6:0] = OP_ADD_SUB;
      if ($urandom_range(1)) ins[31:25] = 7'd0;
    end else if (pick < 36) begin
      ins[6:0] = OP_ADDI;
      if ($urandom_range(9) == 0) ins[31:20] = $urandom_range(1) ? 12'h7ff : 12'h800;
    end else if (pick < 52) begin
      ins[6:0] = OP_SD;
      if ($urandom_range(1)) ins[19:15] = ZERO_REG;
    end else if (pick < 68) begin
      ins = load_from_stored(ins[11:7]);
    end else if (pick < 84) begin
      ins[6:0] = OP_BRANCH;
      if ($urandom_range(5) != 0) ins[14:12] = BRANCH_F3[$urandom_range(3)];
      if ($urandom_range(4) == 0) ins[24:20] = ins[19:15];
    end else if (pick < 90) begin
      ins[6:0] = OP_JAL;
    end else if (ins[6:0] == OP_LD && !sb.load_hits_stored(ins)) begin
      // raw noise must not read an unwritten word
      ins[6] = 1'b1;
    end
    return ins;
  endfunction

  task automatic send_instruction(input logic [INST_W-1:0] ins);
    int unsigned gap;
    in_valid <= 1'b1;
    instruction <= ins;
    do @(posedge clk); while (!in_ready);
    sb.execute_request(ins);
    if (burst_left == 0) begin
      gap = $urandom_range(10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_stack_top(input logic [SP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_stack_top(value);
  endtask

  initial begin
    logic [INST_W-1:0] directed [$];
    logic [SP_W-1:0]   tops [4];
    tops[0] = '0;
    tops[1] = SP_W'(16384);
    tops[2] = SP_W'($urandom_range(16384));
    tops[3] = SP_W'(1);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(enc_i(OP_ADDI, 12'h000, SP_REG, 5'd5));     // reset stack top
    directed.push_back(enc_i(OP_ADDI, 12'h7ff, ZERO_REG, 5'd6));   // largest immediate
    directed.push_back(enc_i(OP_ADDI, 12'h800, ZERO_REG, 5'd7));   // most negative immediate
    directed.push_back(enc_r(7'h00, 5'd7, 5'd6, 5'd8));
    directed.push_back(enc_r(7'h20, 5'd7, 5'd6, 5'd9));
    directed.push_back(enc_r(7'h7f, 5'd6, 5'd7, 5'd10));           // odd funct7 still subtracts
    directed.push_back(enc_r(7'h00, 5'd6, 5'd6, ZERO_REG));        // x0 destination dropped
    directed.push_back(enc_s(12'h000, 5'd8, ZERO_REG));
    directed.push_back(enc_s(12'h7ff, 5'd6, ZERO_REG));
    directed.push_back(enc_s(12'hff8, 5'd7, ZERO_REG));            // wraps to the top word
    directed.push_back(enc_i(OP_LD, 12'h000, ZERO_REG, 5'd11));
    directed.push_back(enc_i(OP_LD, 12'h7f8, ZERO_REG, 5'd12));
    directed.push_back(enc_i(OP_LD, 12'hfff, ZERO_REG, 5'd13));
    directed.push_back(enc_b(F3_BEQ, 13'h0008, 5'd6, 5'd6));
    directed.push_back(enc_b(F3_BNE, 13'h0008, 5'd6, 5'd6));
    directed.push_back(enc_b(F3_BLT, 13'h1000, 5'd7, 5'd6));       // signed compare, taken
    directed.push_back(enc_b(F3_BGE, 13'h0ffe, 5'd7, 5'd6));       // signed compare, not taken
    directed.push_back(enc_b(F3_BGE, 13'h0ffe, 5'd6, 5'd6));
    directed.push_back(enc_b(F3_BLT, 13'h0004, 5'd8, ZERO_REG));
    directed.push_back(enc_b(F3_UNUSED_LO, 13'h0010, 5'd6, 5'd6)); // unused funct3 falls through
    directed.push_back(enc_b(F3_UNUSED_HI, 13'h1ff0, 5'd8, 5'd6));
    directed.push_back(enc_j(21'h0ffffe, 5'd1));
    directed.push_back(enc_j(21'h100000, ZERO_REG));
    directed.push_back(32'h0000_0000);                              // unknown opcodes
    directed.push_back(32'hffff_ffff);
    foreach (directed[i]) send_instruction(directed[i]);

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      load_stack_top(tops[p]);
      if (p == 1) pressure_phase <= 1'b1;
      repeat (350) send_instruction(random_instruction());
    end

    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.failures == 0 && sb.awaited.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: rv64_subset_execute.f
rtl/rv64se_pkg.sv
rtl/rv64se_regfile.sv
rtl/rv64se_dmem.sv
rtl/rv64se_exec.sv
rtl/rv64_subset_execute.sv
test/rv64se_tb_pkg.sv
test/testbench.sv
